// ===== hdl/ptfd_pkg.sv =====
package ptfd_pkg;

    localparam int NUM_SUPPLIES = 2;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = 4;

    typedef enum logic [1:0] {
        REQ_STATUS = 2'd0,
        REQ_POWER  = 2'd1,
        REQ_FAN    = 2'd2,
        REQ_SPARE  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DC   = 2'd1,
        MODE_AC   = 2'd2
    } t_mode;

    typedef struct packed {
        logic cls;
        logic present;
    } t_status;

    typedef struct packed {
        logic    en;
        logic    idx;
        t_status data;
    } t_status_wr;

    typedef struct packed {
        logic        echo_index;
        logic        present;
        logic        supply_class;
        t_mode       mode;
        logic [7:0]  fan_pwm;
        logic [15:0] fan_one;
        logic [15:0] fan_two;
        logic [15:0] fan_three;
    } t_ctl;

    localparam logic [3:0] MASK_NONE = 4'b0000;
    localparam logic [3:0] MASK_DC   = 4'b0111;
    localparam logic [3:0] MASK_AC   = 4'b1011;

    localparam logic signed [20:0] LIN_SCALE = 21'sd1000;
    localparam logic signed [31:0] SAT_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

    localparam longint AC_V_NUM   = 10000;
    localparam longint AC_V_DEN   = 2207;
    localparam longint AC_V_BASE  = 180000;
    localparam int     AC_V_SHIFT = 29;
    localparam logic [16:0] AC_V_OFS = 17'(AC_V_BASE / AC_V_NUM);
    localparam logic [31:0] AC_V_MUL =
        32'((AC_V_NUM * (64'sd1 <<< AC_V_SHIFT) + AC_V_DEN - 1) / AC_V_DEN);

    localparam longint AC_I_NUM   = 1000000;
    localparam longint AC_I_DEN   = 51405;
    localparam longint AC_I_BASE  = 31000000;
    localparam int     AC_I_SHIFT = 33;
    localparam logic [16:0] AC_I_OFS   = 17'(AC_I_BASE / AC_I_NUM);
    localparam logic [20:0] AC_I_WHOLE = 21'(AC_I_NUM / AC_I_DEN);
    localparam longint AC_I_REM   = AC_I_NUM - (AC_I_NUM / AC_I_DEN) * AC_I_DEN;
    localparam logic [31:0] AC_I_MUL =
        32'((AC_I_REM * (64'sd1 <<< AC_I_SHIFT) + AC_I_DEN - 1) / AC_I_DEN);

endpackage

// ===== hdl/ptfd_status_table.sv =====
module ptfd_status_table
    import ptfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_status_wr i_wr,
    input  logic       i_rd_idx,
    output t_status    o_rd_data
);

    t_status r_status [NUM_SUPPLIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SUPPLIES; i++) begin
                r_status[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_status[i_wr.idx] <= i_wr.data;
        end
    end

    assign o_rd_data = r_status[i_rd_idx];

endmodule

// ===== hdl/ptfd_lin11_lane.sv =====
module ptfd_lin11_lane
    import ptfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_word,
    output logic [31:0] o_milli
);

    logic signed [10:0] mant;
    logic signed [20:0] n_prod;
    logic signed [20:0] r_prod;
    logic signed [4:0]  r_exp;
    logic signed [35:0] ext;
    logic signed [35:0] shl;
    logic signed [35:0] rnd;
    logic signed [35:0] shr;
    logic [3:0]         up;
    logic [4:0]         dn;
    logic [16:0]        bias;

    assign mant   = i_word[10:0];
    assign n_prod = 21'(mant) * LIN_SCALE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_exp  <= i_word[15:11];
        end
    end

    always_comb begin
        ext  = 36'(r_prod);
        up   = r_exp[3:0];
        dn   = ~r_exp + 5'd1;
        shl  = ext <<< up;
        bias = r_prod[20] ? 17'((18'd1 << dn) - 18'd1) : 17'd0;
        rnd  = ext + $signed({19'd0, bias});
        shr  = rnd >>> dn;
        if (r_exp[4]) begin
            o_milli = shr[31:0];
        end else if (shl[35:31] != {5{shl[35]}}) begin
            o_milli = shl[35] ? SAT_MIN : SAT_MAX;
        end else begin
            o_milli = shl[31:0];
        end
    end

endmodule

// ===== hdl/ptfd_ac_scale.sv =====
module ptfd_ac_scale
    import ptfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_w0,
    input  logic [15:0] i_w1,
    input  logic [15:0] i_w3,
    output logic [31:0] o_vin,
    output logic [31:0] o_vout,
    output logic [30:0] o_iin
);

    logic [16:0] x0;
    logic [16:0] x1;
    logic [16:0] x3;
    logic [48:0] r_vin_p;
    logic [48:0] r_vout_p;
    logic [48:0] r_iin_p;
    logic [16:0] r_iin_x;
    logic [20:0] whole;

    assign x0 = {1'b0, i_w0} + AC_V_OFS;
    assign x1 = {1'b0, i_w1} + AC_V_OFS;
    assign x3 = {1'b0, i_w3} + AC_I_OFS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vin_p  <= 49'(x0) * 49'(AC_V_MUL);
            r_vout_p <= 49'(x1) * 49'(AC_V_MUL);
            r_iin_p  <= 49'(x3) * 49'(AC_I_MUL);
            r_iin_x  <= x3;
        end
    end

    assign whole  = 21'(r_iin_x) * AC_I_WHOLE;
    assign o_vin  = 32'(r_vin_p[48:AC_V_SHIFT]);
    assign o_vout = 32'(r_vout_p[48:AC_V_SHIFT]);
    assign o_iin  = 31'(whole + 21'(r_iin_p[48:AC_I_SHIFT]));

endmodule

// ===== hdl/psu_telemetry_frame_decoder.sv =====
// Channel   Dir  Beat contents
// s (in)    in   tuser: req_type, frame_ok; tdata: supply_index, word_zero..word_three
// m (out)   out  tuser: valid_mask; tdata: index, status, fan_pwm, readings, fan rpm
//
// One beat in, one beat out; a new beat is taken every cycle unless a stalled output backs up the stages.
// Each beat passes through the input register, the product register and the result register.
// The product register holds the constant multiplies of the AC scalings and LINEAR11.
// Reset clears the stage valid bits and the supply status table at once.
// Each stage advances when the one after it is empty or advancing, so the input
// side takes up to two more beats while a result waits in the output register, then holds.
module psu_telemetry_frame_decoder
    import ptfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // supply_index, word_zero, word_one, word_two, word_three, zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type, frame_ok
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // echo_index, present, supply_class, fan_pwm, vin_milli, vout_milli,
    // iout_milli, iin_milli, fan_one_rpm, fan_two_rpm, fan_three_rpm, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // valid_mask
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    logic       en_a;
    logic       en_b;
    logic       en_c;

    logic       r_a_vld;
    t_req_kind  r_a_kind;
    logic       r_a_idx;
    logic       r_a_ok;
    logic [15:0] r_a_w0;
    logic [15:0] r_a_w1;
    logic [15:0] r_a_w2;
    logic [15:0] r_a_w3;

    logic       r_b_vld;
    t_ctl       r_b_ctl;
    t_ctl       n_b_ctl;

    logic                 r_c_vld;
    logic [M_TDATA_W-1:0] r_c_data;
    logic [M_TDATA_W-1:0] n_c_data;
    logic [3:0]           r_c_mask;
    logic [3:0]           n_c_mask;

    logic       idx_ok;
    t_status    st_cur;
    t_status    st_new;
    t_status_wr st_wr;

    logic [31:0] dc_vin;
    logic [31:0] dc_vout;
    logic [31:0] dc_iout;
    logic [31:0] ac_vin;
    logic [31:0] ac_vout;
    logic [30:0] ac_iin;

    logic [31:0] vin;
    logic [31:0] vout;
    logic [31:0] iout;
    logic [30:0] iin;

    assign en_c       = !r_c_vld || i_m_tready;
    assign en_b       = !r_b_vld || en_c;
    assign en_a       = !r_a_vld || en_b;
    assign o_s_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_s_tvalid;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (en_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_kind <= t_req_kind'(i_s_tuser[1:0]);
            r_a_ok   <= i_s_tuser[2];
            r_a_idx  <= i_s_tdata[0];
            r_a_w0   <= i_s_tdata[16:1];
            r_a_w1   <= i_s_tdata[32:17];
            r_a_w2   <= i_s_tdata[48:33];
            r_a_w3   <= i_s_tdata[64:49];
        end
        if (en_b) begin
            r_b_ctl <= n_b_ctl;
        end
        if (en_c) begin
            r_c_data <= n_c_data;
            r_c_mask <= n_c_mask;
        end
    end

    ptfd_status_table u_status (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (st_wr),
        .i_rd_idx  (r_a_idx),
        .o_rd_data (st_cur)
    );

    always_comb begin
        idx_ok        = {31'd0, r_a_idx} < 32'(NUM_SUPPLIES);
        st_wr.en      = r_a_vld && en_b && idx_ok && (r_a_kind == REQ_STATUS);
        st_wr.idx     = r_a_idx;
        st_wr.data    = r_a_ok ? t_status'{cls: r_a_w2[9], present: 1'b1} : '0;
        st_new        = (r_a_kind == REQ_STATUS) ? st_wr.data : st_cur;

        n_b_ctl            = '0;
        n_b_ctl.echo_index = r_a_idx;
        if (idx_ok) begin
            n_b_ctl.present      = st_new.present;
            n_b_ctl.supply_class = st_new.cls;
            unique case (r_a_kind)
                REQ_STATUS: begin
                    n_b_ctl.fan_pwm = r_a_ok ? r_a_w0[7:0] : 8'd0;
                end
                REQ_POWER: begin
                    if (r_a_ok && st_cur.present) begin
                        n_b_ctl.mode = st_cur.cls ? MODE_AC : MODE_DC;
                    end
                end
                REQ_FAN: begin
                    if (r_a_ok) begin
                        n_b_ctl.fan_one   = r_a_w0;
                        n_b_ctl.fan_two   = r_a_w1;
                        n_b_ctl.fan_three = r_a_w2;
                    end
                end
                REQ_SPARE: begin
                    n_b_ctl.mode = MODE_NONE;
                end
            endcase
        end
    end

    ptfd_lin11_lane u_lin_vin (
        .i_clk   (i_clk),
        .i_en    (en_b),
        .i_word  (r_a_w0),
        .o_milli (dc_vin)
    );

    ptfd_lin11_lane u_lin_vout (
        .i_clk   (i_clk),
        .i_en    (en_b),
        .i_word  (r_a_w1),
        .o_milli (dc_vout)
    );

    ptfd_lin11_lane u_lin_iout (
        .i_clk   (i_clk),
        .i_en    (en_b),
        .i_word  (r_a_w2),
        .o_milli (dc_iout)
    );

    ptfd_ac_scale u_ac (
        .i_clk  (i_clk),
        .i_en   (en_b),
        .i_w0   (r_a_w0),
        .i_w1   (r_a_w1),
        .i_w3   (r_a_w3),
        .o_vin  (ac_vin),
        .o_vout (ac_vout),
        .o_iin  (ac_iin)
    );

    always_comb begin
        vin      = '0;
        vout     = '0;
        iout     = '0;
        iin      = '0;
        n_c_mask = MASK_NONE;
        unique case (r_b_ctl.mode)
            MODE_DC: begin
                vin      = dc_vin;
                vout     = dc_vout;
                iout     = dc_iout;
                n_c_mask = MASK_DC;
            end
            MODE_AC: begin
                vin      = ac_vin;
                vout     = ac_vout;
                iin      = ac_iin;
                n_c_mask = MASK_AC;
            end
            default: begin
                n_c_mask = MASK_NONE;
            end
        endcase
        n_c_data = {6'd0, r_b_ctl.fan_three, r_b_ctl.fan_two, r_b_ctl.fan_one,
                    iin, iout, vout, vin, r_b_ctl.fan_pwm,
                    r_b_ctl.supply_class, r_b_ctl.present, r_b_ctl.echo_index};
    end

    assign o_m_tvalid = r_c_vld;
    assign o_m_tdata  = r_c_data;
    assign o_m_tuser  = r_c_mask;

`ifndef SYNTHESIS
    a_mask_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_c_mask == MASK_NONE || r_c_mask == MASK_DC
                        || r_c_mask == MASK_AC))
        else $error("unexpected valid mask");

    a_reading_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_c_mask != MASK_NONE) |-> r_c_data[1])
        else $error("reading from an absent supply");

    a_pwm_no_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_c_data[10:3] != 8'd0) |-> r_c_mask == MASK_NONE)
        else $error("fan pwm alongside readings");

    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !en_b |=> r_a_vld && $stable(r_a_w0) && $stable(r_a_idx))
        else $error("stalled input stage lost its beat");
`endif

endmodule
